[hw/rtl/mpl_pkg.sv]
// shared types, codes and constants of the motor positioner with limits
// depends on nothing; imported by every module of the block
package mpl_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEB_A      = 3'd0,
    CFG_DEB_B      = 3'd1,
    CFG_ENC_TMO    = 3'd2,
    CFG_ENABLE     = 3'd3,
    CFG_INVERT     = 3'd4,
    CFG_MARGIN     = 3'd5
  } cfg_idx_e;

  // transaction action codes
  typedef enum logic [3:0] {
    ACT_INIT  = 4'd0,
    ACT_TICK  = 4'd1,
    ACT_ENC   = 4'd2,
    ACT_LIM_A = 4'd3,
    ACT_LIM_B = 4'd4,
    ACT_HOME  = 4'd5,
    ACT_FWD   = 4'd6,
    ACT_REV   = 4'd7,
    ACT_GOTO  = 4'd8
  } action_e;

  // run state machine, one-hot
  typedef enum logic [5:0] {
    RUN_IDLE    = 6'b000001,
    RUN_FWD     = 6'b000010,
    RUN_REV     = 6'b000100,
    RUN_LIMIT   = 6'b001000,
    RUN_POS     = 6'b010000,
    RUN_TIMEOUT = 6'b100000
  } run_e;

  // run state codes as seen on the result
  localparam logic [2:0] RUN_CODE_IDLE    = 3'd0;
  localparam logic [2:0] RUN_CODE_FWD     = 3'd1;
  localparam logic [2:0] RUN_CODE_REV     = 3'd2;
  localparam logic [2:0] RUN_CODE_LIMIT   = 3'd3;
  localparam logic [2:0] RUN_CODE_POS     = 3'd4;
  localparam logic [2:0] RUN_CODE_TIMEOUT = 3'd5;

  // limit switch state machine, one-hot
  typedef enum logic [2:0] {
    SW_LOW  = 3'b001,
    SW_WAIT = 3'b010,
    SW_HIGH = 3'b100
  } sw_e;

  localparam logic [31:0] POS_MIN = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [31:0] DEB_RESET     = 32'd10000;
  localparam logic [31:0] ENC_TMO_RESET = 32'd100000;
  localparam logic [2:0]  ENABLE_RESET  = 3'b111;
  localparam logic [1:0]  INVERT_RESET  = 2'b00;
  localparam logic [15:0] MARGIN_RESET  = 16'd0;

  // enable bits
  localparam int unsigned EN_ENC = 2;

  typedef struct packed {
    logic [31:0] deb_a;
    logic [31:0] deb_b;
    logic [31:0] enc_tmo;
    logic [2:0]  enable;
    logic [1:0]  invert;
    logic [15:0] margin;
  } cfg_t;

  // core to switch debouncer
  typedef struct packed {
    logic change_en;
    logic active;
    logic tick_en;
    logic force_high;
  } sw_ctl_t;

  // switch debouncer to core
  typedef struct packed {
    logic        high;
    logic        deb_fire;
    logic        high_next;
    logic [31:0] trig_pos;
  } sw_stat_t;

  typedef struct packed {
    logic        motor_fwd;
    logic        motor_rev;
    logic [2:0]  run_state;
    logic [31:0] position;
    logic        limit_a_hit;
    logic        limit_b_hit;
    logic [31:0] limit_a_pos;
    logic [31:0] limit_b_pos;
    logic        home_set;
    logic        accepted;
    logic        settled;
  } result_t;

  function automatic logic [2:0] run_code(run_e r);
    logic [2:0] c;
    unique case (r)
      RUN_IDLE:    c = RUN_CODE_IDLE;
      RUN_FWD:     c = RUN_CODE_FWD;
      RUN_REV:     c = RUN_CODE_REV;
      RUN_LIMIT:   c = RUN_CODE_LIMIT;
      RUN_POS:     c = RUN_CODE_POS;
      RUN_TIMEOUT: c = RUN_CODE_TIMEOUT;
      default:     c = RUN_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/motor_positioner_with_limits.sv]
// top level of the motor positioner with limits: input and result registers,
// configuration registers; depends on mpl_pkg, mpl_core, mpl_sw_debounce
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one action per transaction:
//   init, tick, encoder edge, limit A/B level change, home, forward, reverse
//   or go-to. Each transaction gives exactly one result transaction on the
//   output channel (out_valid_o/out_ready_i) with drive outputs, run state,
//   position, switch status and accept/settle flags.
//   Timing: a transaction is registered in the input register on acceptance,
//   processed once the result register is free or being drained, and its
//   result is loaded into the result register, which raises out_valid_o.
//   Throughput: one transaction per cycle while unstalled; the state update
//   is a single pass of compare and add logic between the input and result
//   registers. When the receiver stalls, the result is held and one more
//   transaction can wait in the input register; in_ready_o drops after that.
//   Reset clears both channels, loads the configuration defaults and puts
//   the run state at idle with no positions latched.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   once and are meant for an idle block.
module motor_positioner_with_limits import mpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic [31:0] target_i,
  input  logic [31:0] home_pos_i,
  input  logic [31:0] far_pos_i,
  input  logic        pin_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        motor_fwd_o,
  output logic        motor_rev_o,
  output logic [2:0]  run_state_o,
  output logic [31:0] position_o,
  output logic        limit_a_hit_o,
  output logic        limit_b_hit_o,
  output logic [31:0] limit_a_pos_o,
  output logic [31:0] limit_b_pos_o,
  output logic        home_set_o,
  output logic        accepted_o,
  output logic        settled_o
);

  cfg_t        cfg_q;
  logic        in_valid_q;
  logic [3:0]  action_q;
  logic [31:0] target_q, home_pos_q, far_pos_q;
  logic        pin_level_q;
  logic        out_valid_q;
  result_t     result_q, result_d;
  logic        fire;
  sw_ctl_t  [1:0] sw_ctl;
  sw_stat_t [1:0] sw_stat;
  logic [31:0] raw_pos;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deb_a   <= DEB_RESET;
      cfg_q.deb_b   <= DEB_RESET;
      cfg_q.enc_tmo <= ENC_TMO_RESET;
      cfg_q.enable  <= ENABLE_RESET;
      cfg_q.invert  <= INVERT_RESET;
      cfg_q.margin  <= MARGIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEB_A:   cfg_q.deb_a   <= cfg_data_i;
        CFG_DEB_B:   cfg_q.deb_b   <= cfg_data_i;
        CFG_ENC_TMO: cfg_q.enc_tmo <= cfg_data_i;
        CFG_ENABLE:  cfg_q.enable  <= cfg_data_i[2:0];
        CFG_INVERT:  cfg_q.invert  <= cfg_data_i[1:0];
        CFG_MARGIN:  cfg_q.margin  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // handshake: process when the result register is free or being drained
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q    <= action_i;
      target_q    <= target_i;
      home_pos_q  <= home_pos_i;
      far_pos_q   <= far_pos_i;
      pin_level_q <= pin_level_i;
    end
    if (fire) begin
      result_q <= result_d;
    end
  end

  mpl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .action_i    (action_q),
    .target_i    (target_q),
    .home_pos_i  (home_pos_q),
    .far_pos_i   (far_pos_q),
    .pin_level_i (pin_level_q),
    .cfg_i       (cfg_q),
    .sw_stat_i   (sw_stat),
    .sw_ctl_o    (sw_ctl),
    .raw_pos_o   (raw_pos),
    .result_o    (result_d)
  );

  mpl_sw_debounce u_sw_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (sw_ctl[0]),
    .raw_pos_i (raw_pos),
    .limit_i   (cfg_q.deb_a),
    .stat_o    (sw_stat[0])
  );

  mpl_sw_debounce u_sw_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (sw_ctl[1]),
    .raw_pos_i (raw_pos),
    .limit_i   (cfg_q.deb_b),
    .stat_o    (sw_stat[1])
  );

  // result ports
  assign out_valid_o   = out_valid_q;
  assign motor_fwd_o   = result_q.motor_fwd;
  assign motor_rev_o   = result_q.motor_rev;
  assign run_state_o   = result_q.run_state;
  assign position_o    = result_q.position;
  assign limit_a_hit_o = result_q.limit_a_hit;
  assign limit_b_hit_o = result_q.limit_b_hit;
  assign limit_a_pos_o = result_q.limit_a_pos;
  assign limit_b_pos_o = result_q.limit_b_pos;
  assign home_set_o    = result_q.home_set;
  assign accepted_o    = result_q.accepted;
  assign settled_o     = result_q.settled;

endmodule

[hw/rtl/mpl_sw_debounce.sv]
// one limit switch: level tracking, debounce counter and trigger position
// depends on mpl_pkg
module mpl_sw_debounce import mpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sw_ctl_t     ctl_i,
  input  logic [31:0] raw_pos_i,
  input  logic [31:0] limit_i,
  output sw_stat_t    stat_o
);

  sw_e         mode_q, mode_d;
  logic [31:0] bounce_q, bounce_d;
  logic [31:0] trig_q, trig_d;
  logic        deb_fire;
  logic        deb_cond;

  // counter after the saturating increment exceeds the limit
  assign deb_cond = (bounce_q == CNT_MAX) ? (limit_i != CNT_MAX) : (bounce_q >= limit_i);

  // next state of the switch
  always_comb begin
    mode_d   = mode_q;
    bounce_d = bounce_q;
    trig_d   = trig_q;
    deb_fire = 1'b0;
    if (ctl_i.change_en) begin
      unique case (mode_q)
        SW_LOW: begin
          if (ctl_i.active) begin
            mode_d   = SW_WAIT;
            bounce_d = '0;
            trig_d   = raw_pos_i;
          end
        end
        SW_WAIT: begin
          if (ctl_i.active) begin
            bounce_d = '0;
            trig_d   = raw_pos_i;
          end else begin
            mode_d   = SW_LOW;
            bounce_d = '0;
            trig_d   = '0;
          end
        end
        SW_HIGH: begin
          if (!ctl_i.active) begin
            mode_d   = SW_LOW;
            bounce_d = '0;
            trig_d   = '0;
          end
        end
        default: mode_d = SW_LOW;
      endcase
    end
    // debounce on tick
    if (ctl_i.tick_en && mode_q == SW_WAIT) begin
      bounce_d = (bounce_q == CNT_MAX) ? bounce_q : bounce_q + 32'd1;
      deb_fire = deb_cond;
      if (deb_cond) begin
        mode_d = SW_HIGH;
      end
    end
    // encoder timeout marks a pending switch as hit
    if (ctl_i.force_high && mode_d == SW_WAIT) begin
      mode_d = SW_HIGH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= SW_LOW;
      bounce_q <= '0;
      trig_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      bounce_q <= bounce_d;
      trig_q   <= trig_d;
    end
  end

  assign stat_o.high      = (mode_q == SW_HIGH);
  assign stat_o.deb_fire  = deb_fire;
  assign stat_o.high_next = (mode_d == SW_HIGH);
  assign stat_o.trig_pos  = trig_q;

endmodule

[hw/rtl/mpl_core.sv]
// run control, position, encoder watchdog and latched switch positions
// depends on mpl_pkg; drives the two mpl_sw_debounce instances
module mpl_core import mpl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [3:0]        action_i,
  input  logic [31:0]       target_i,
  input  logic [31:0]       home_pos_i,
  input  logic [31:0]       far_pos_i,
  input  logic              pin_level_i,
  input  cfg_t              cfg_i,
  input  sw_stat_t [1:0]    sw_stat_i,
  output sw_ctl_t  [1:0]    sw_ctl_o,
  output logic [31:0]       raw_pos_o,
  output result_t           result_o
);

  run_e        run_q, run_d;
  logic [31:0] raw_q, raw_d;
  logic [31:0] dest_q, dest_d;
  logic        margin_q, margin_d;
  logic        started_q, started_d;
  logic [31:0] idle_q, idle_d;
  logic        armed_q, armed_d;
  logic [31:0] swpos_q [2];
  logic [31:0] swpos_d [2];
  logic [1:0]  swval_q, swval_d;

  logic        running;
  logic        idle_cond;
  logic        fwd_stop, rev_stop;
  logic signed [33:0] p_ext, d_ext, m_ext;
  logic [1:0]  force_high;
  logic        is_tick;
  logic        accepted, settled;
  logic        begin_run;
  logic        known;
  logic [31:0] pos0_init;

  assign running = (run_q == RUN_FWD) || (run_q == RUN_REV);
  assign is_tick = fire_i && (action_i == ACT_TICK);

  // idle counter after the saturating increment exceeds the timeout
  assign idle_cond = (idle_q == CNT_MAX) ? (cfg_i.enc_tmo != CNT_MAX)
                                         : (idle_q >= cfg_i.enc_tmo);

  // position stop compare at full precision
  assign p_ext    = {{2{raw_q[31]}}, raw_q};
  assign d_ext    = {{2{dest_q[31]}}, dest_q};
  assign m_ext    = margin_q ? {18'd0, cfg_i.margin} : 34'sd0;
  assign fwd_stop = (p_ext + m_ext) >= d_ext;
  assign rev_stop = (p_ext - m_ext) <= d_ext;

  assign known     = (target_i != '0) && (home_pos_i != '0);
  assign pos0_init = known ? home_pos_i : '0;

  // next state for one transaction
  always_comb begin
    run_d      = run_q;
    raw_d      = raw_q;
    dest_d     = dest_q;
    margin_d   = margin_q;
    started_d  = started_q;
    idle_d     = idle_q;
    armed_d    = armed_q;
    swpos_d    = swpos_q;
    swval_d    = swval_q;
    force_high = 2'b00;
    accepted   = 1'b1;
    settled    = 1'b1;
    begin_run  = 1'b0;
    unique case (action_i)
      ACT_INIT: begin
        if (!started_q) begin
          started_d  = 1'b1;
          swval_d[0] = known;
          swpos_d[0] = pos0_init;
          swpos_d[1] = far_pos_i;
          raw_d      = target_i + pos0_init;
          run_d      = RUN_IDLE;
        end
      end
      ACT_TICK: begin
        // debounced switches latch their trigger position
        for (int s = 0; s < 2; s++) begin
          if (sw_stat_i[s].deb_fire && !swval_q[s]) begin
            swpos_d[s] = sw_stat_i[s].trig_pos;
            swval_d[s] = 1'b1;
          end
        end
        if (cfg_i.enable[EN_ENC] && armed_q) begin
          idle_d = (idle_q == CNT_MAX) ? idle_q : idle_q + 32'd1;
        end
        if (cfg_i.enable[EN_ENC] && armed_q && idle_cond && running) begin
          // encoder timeout marks the approached limit here
          if (run_q == RUN_FWD) begin
            force_high[1] = 1'b1;
            if (!swval_d[1]) begin
              swpos_d[1] = raw_q;
              swval_d[1] = 1'b1;
            end
          end else begin
            force_high[0] = 1'b1;
            if (!swval_d[0]) begin
              swpos_d[0] = raw_q;
              swval_d[0] = 1'b1;
            end
          end
          run_d   = RUN_TIMEOUT;
          settled = 1'b0;
        end else if (run_q == RUN_IDLE) begin
          settled = 1'b1;
        end else if (!running) begin
          settled = 1'b0;
        end else if (run_q == RUN_FWD) begin
          if (sw_stat_i[1].high || sw_stat_i[1].deb_fire) begin
            run_d   = RUN_LIMIT;
            settled = 1'b0;
          end else if (fwd_stop) begin
            margin_d = 1'b0;
            run_d    = RUN_POS;
            settled  = 1'b0;
          end
        end else begin
          if (sw_stat_i[0].high || sw_stat_i[0].deb_fire) begin
            run_d   = RUN_LIMIT;
            settled = 1'b0;
          end else if (rev_stop) begin
            margin_d = 1'b0;
            run_d    = RUN_POS;
            settled  = 1'b0;
          end
        end
      end
      ACT_ENC: begin
        if (started_q && cfg_i.enable[EN_ENC] && running) begin
          raw_d   = (run_q == RUN_FWD) ? raw_q + 32'd1 : raw_q - 32'd1;
          armed_d = 1'b1;
          idle_d  = '0;
        end
      end
      ACT_LIM_A, ACT_LIM_B: begin
        // handled in the switch debouncers
      end
      ACT_HOME: begin
        dest_d     = POS_MIN;
        swval_d[0] = 1'b0;
        begin_run  = 1'b1;
      end
      ACT_FWD: begin
        if ($signed(target_i) <= 32'sd0) begin
          dest_d     = POS_MAX;
          swval_d[1] = 1'b0;
        end else begin
          dest_d = raw_q + target_i;
        end
        begin_run = 1'b1;
      end
      ACT_REV: begin
        if ($signed(target_i) > 32'sd0) begin
          dest_d    = raw_q - target_i;
          begin_run = 1'b1;
        end else begin
          accepted = 1'b0;
        end
      end
      ACT_GOTO: begin
        if (swval_q[0] && (run_q == RUN_IDLE || running)) begin
          dest_d    = target_i + swpos_q[0];
          begin_run = 1'b1;
        end else begin
          accepted = 1'b0;
        end
      end
      default: accepted = 1'b0;
    endcase
    // start a run toward the new destination
    if (begin_run) begin
      run_d   = ($signed(dest_d) > $signed(raw_q)) ? RUN_FWD : RUN_REV;
      armed_d = 1'b1;
      idle_d  = '0;
    end
  end

  // state registers, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= RUN_IDLE;
      raw_q      <= '0;
      dest_q     <= '0;
      margin_q   <= 1'b1;
      started_q  <= 1'b0;
      idle_q     <= '0;
      armed_q    <= 1'b0;
      swpos_q[0] <= '0;
      swpos_q[1] <= '0;
      swval_q    <= 2'b00;
    end else if (fire_i) begin
      run_q      <= run_d;
      raw_q      <= raw_d;
      dest_q     <= dest_d;
      margin_q   <= margin_d;
      started_q  <= started_d;
      idle_q     <= idle_d;
      armed_q    <= armed_d;
      swpos_q[0] <= swpos_d[0];
      swpos_q[1] <= swpos_d[1];
      swval_q    <= swval_d;
    end
  end

  // switch control
  assign sw_ctl_o[0].change_en  = fire_i && (action_i == ACT_LIM_A) && started_q
                                  && cfg_i.enable[0];
  assign sw_ctl_o[1].change_en  = fire_i && (action_i == ACT_LIM_B) && started_q
                                  && cfg_i.enable[1];
  assign sw_ctl_o[0].active     = pin_level_i ^ cfg_i.invert[0];
  assign sw_ctl_o[1].active     = pin_level_i ^ cfg_i.invert[1];
  assign sw_ctl_o[0].tick_en    = is_tick && cfg_i.enable[0];
  assign sw_ctl_o[1].tick_en    = is_tick && cfg_i.enable[1];
  assign sw_ctl_o[0].force_high = fire_i && force_high[0];
  assign sw_ctl_o[1].force_high = fire_i && force_high[1];
  assign raw_pos_o              = raw_q;

  // result from the updated state
  assign result_o.motor_fwd   = (run_d == RUN_FWD);
  assign result_o.motor_rev   = (run_d == RUN_REV);
  assign result_o.run_state   = run_code(run_d);
  assign result_o.position    = swval_d[0] ? raw_d - swpos_d[0] : raw_d;
  assign result_o.limit_a_hit = sw_stat_i[0].high_next;
  assign result_o.limit_b_hit = sw_stat_i[1].high_next;
  assign result_o.limit_a_pos = swval_d[0] ? swpos_d[0] : '0;
  assign result_o.limit_b_pos = swval_d[1] ? swpos_d[1] : '0;
  assign result_o.home_set    = swval_d[0];
  assign result_o.accepted    = accepted;
  assign result_o.settled     = settled;

endmodule

[hw/rtl/mpl_checker.sv]
// port-level checks of the motor positioner with limits, bound to the top
// depends on mpl_pkg and motor_positioner_with_limits
module mpl_checker import mpl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        motor_fwd_o,
  input logic        motor_rev_o,
  input logic [2:0]  run_state_o,
  input logic [31:0] position_o,
  input logic        home_set_o,
  input logic [31:0] limit_a_pos_o
);

  // drive outputs follow the run state
  a_fwd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_fwd_o == (run_state_o == RUN_CODE_FWD)))
    else $error("motor_fwd does not match run state");

  a_rev_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_rev_o == (run_state_o == RUN_CODE_REV)))
    else $error("motor_rev does not match run state");

  // no home latched means no home position reported
  a_home_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !home_set_o) |-> (limit_a_pos_o == '0))
    else $error("limit A position reported without home");

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(position_o)))
    else $error("stalled result changed");

endmodule

bind motor_positioner_with_limits mpl_checker u_mpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .motor_fwd_o   (motor_fwd_o),
  .motor_rev_o   (motor_rev_o),
  .run_state_o   (run_state_o),
  .position_o    (position_o),
  .home_set_o    (home_set_o),
  .limit_a_pos_o (limit_a_pos_o)
);

[dv/motor_positioner_with_limits_tb.sv]
// self-checking testbench for motor_positioner_with_limits: directed and random
// transactions checked against an in-bench predictor of the positioner
// depends on mpl_pkg and the motor_positioner_with_limits rtl
module motor_positioner_with_limits_tb;
  import mpl_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int CHUNK_ITEMS = 80;
  localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  typedef struct {
    logic [3:0]  act;
    logic [31:0] tgt;
    logic [31:0] home;
    logic [31:0] far;
    logic        pin;
  } item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  action_i = '0;
  logic [31:0] target_i = '0;
  logic [31:0] home_pos_i = '0;
  logic [31:0] far_pos_i = '0;
  logic        pin_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        motor_fwd_o;
  logic        motor_rev_o;
  logic [2:0]  run_state_o;
  logic [31:0] position_o;
  logic        limit_a_hit_o;
  logic        limit_b_hit_o;
  logic [31:0] limit_a_pos_o;
  logic [31:0] limit_b_pos_o;
  logic        home_set_o;
  logic        accepted_o;
  logic        settled_o;

  motor_positioner_with_limits dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state and its copy of the registers
  cfg_t        regs;
  logic [2:0]  drive_mode;
  logic [31:0] count_pos;
  logic [31:0] goal_pos;
  bit          margin_live;
  bit          booted;
  logic [31:0] enc_quiet;
  bit          enc_watch;
  sw_e         sw_state [2];
  logic [31:0] sw_trig [2];
  logic [31:0] sw_dwell [2];
  logic [31:0] sw_mark [2];
  bit          sw_mark_ok [2];

  // stimulus and scoreboard
  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   cur_item;
  result_t got;
  result_t want;
  int      errors = 0;
  int      send_gap_pct = 0;
  int      recv_gap_pct = 0;
  int unsigned quiet_cycles = 0;

  task automatic reset_model();
    regs.deb_a = DEB_RESET;
    regs.deb_b = DEB_RESET;
    regs.enc_tmo = ENC_TMO_RESET;
    regs.enable = ENABLE_RESET;
    regs.invert = INVERT_RESET;
    regs.margin = MARGIN_RESET;
    drive_mode = RUN_CODE_IDLE;
    count_pos = '0;
    goal_pos = '0;
    margin_live = 1'b1;
    booted = 1'b0;
    enc_quiet = '0;
    enc_watch = 1'b0;
    for (int s = 0; s < 2; s++) begin
      sw_state[s] = SW_LOW;
      sw_trig[s] = '0;
      sw_dwell[s] = '0;
      sw_mark[s] = '0;
      sw_mark_ok[s] = 1'b0;
    end
  endtask

  // switch position is latched once; a pending switch becomes active
  function automatic void mark_switch(int s, logic [31:0] at);
    if (!sw_mark_ok[s]) begin
      sw_mark[s] = at;
      sw_mark_ok[s] = 1'b1;
    end
    if (sw_state[s] == SW_WAIT) sw_state[s] = SW_HIGH;
  endfunction

  function automatic void start_motion();
    drive_mode = ($signed(goal_pos) > $signed(count_pos)) ? RUN_CODE_FWD : RUN_CODE_REV;
    enc_watch = 1'b1;
    enc_quiet = '0;
  endfunction

  function automatic void switch_level(int s, logic level);
    logic active;
    active = level ^ regs.invert[s];
    case (sw_state[s])
      SW_LOW: begin
        if (active) begin
          sw_state[s] = SW_WAIT;
          sw_dwell[s] = '0;
          sw_trig[s] = count_pos;
        end
      end
      SW_WAIT: begin
        if (active) begin
          sw_dwell[s] = '0;
          sw_trig[s] = count_pos;
        end else begin
          sw_state[s] = SW_LOW;
          sw_dwell[s] = '0;
          sw_trig[s] = '0;
        end
      end
      default: begin
        if (!active) begin
          sw_state[s] = SW_LOW;
          sw_dwell[s] = '0;
          sw_trig[s] = '0;
        end
      end
    endcase
  endfunction

  // one microsecond: debounce, encoder watchdog, then limit and position stops
  function automatic bit tick_update();
    logic [2:0]  was;
    logic [31:0] lim;
    longint      p;
    longint      d;
    longint      m;
    int          s;
    int          far_side;
    bit          stop;
    was = drive_mode;
    for (s = 0; s < 2; s++) begin
      lim = s ? regs.deb_b : regs.deb_a;
      if (regs.enable[s] && sw_state[s] == SW_WAIT) begin
        if (sw_dwell[s] != CNT_MAX) sw_dwell[s]++;
        if (sw_dwell[s] > lim) mark_switch(s, sw_trig[s]);
      end
    end
    if (regs.enable[EN_ENC] && enc_watch) begin
      if (enc_quiet != CNT_MAX) enc_quiet++;
      if (enc_quiet > regs.enc_tmo &&
          (drive_mode == RUN_CODE_FWD || drive_mode == RUN_CODE_REV)) begin
        mark_switch((drive_mode == RUN_CODE_FWD) ? 1 : 0, count_pos);
        drive_mode = RUN_CODE_TIMEOUT;
        return was == drive_mode;
      end
    end
    if (drive_mode == RUN_CODE_IDLE) return 1'b1;
    if (drive_mode != RUN_CODE_FWD && drive_mode != RUN_CODE_REV) return 1'b0;
    far_side = (drive_mode == RUN_CODE_FWD) ? 1 : 0;
    if (sw_state[far_side] == SW_HIGH) begin
      drive_mode = RUN_CODE_LIMIT;
      return was == drive_mode;
    end
    m = margin_live ? longint'(regs.margin) : 0;
    p = $signed(count_pos);
    d = $signed(goal_pos);
    stop = (drive_mode == RUN_CODE_FWD) ? (p + m >= d) : (p - m <= d);
    if (stop) begin
      margin_live = 1'b0;
      drive_mode = RUN_CODE_POS;
    end
    return was == drive_mode;
  endfunction

  // advance the predictor by one transaction and form its result
  function automatic result_t positioner_step(item_t it);
    result_t r;
    bit      ok;
    bit      calm;
    bit      known;
    int      s;
    ok = 1'b1;
    calm = 1'b1;
    case (it.act)
      ACT_INIT: begin
        if (!booted) begin
          known = (it.tgt != 0) && (it.home != 0);
          booted = 1'b1;
          sw_mark_ok[0] = known;
          sw_mark[0] = known ? it.home : '0;
          sw_mark[1] = it.far;
          count_pos = it.tgt + sw_mark[0];
          drive_mode = RUN_CODE_IDLE;
        end
      end
      ACT_TICK: calm = tick_update();
      ACT_ENC: begin
        if (booted && regs.enable[EN_ENC] &&
            (drive_mode == RUN_CODE_FWD || drive_mode == RUN_CODE_REV)) begin
          count_pos += (drive_mode == RUN_CODE_FWD) ? 32'd1 : CNT_MAX;
          enc_watch = 1'b1;
          enc_quiet = '0;
        end
      end
      ACT_LIM_A, ACT_LIM_B: begin
        s = (it.act == ACT_LIM_B) ? 1 : 0;
        if (booted && regs.enable[s]) switch_level(s, it.pin);
      end
      ACT_HOME: begin
        goal_pos = POS_MIN;
        sw_mark_ok[0] = 1'b0;
        start_motion();
      end
      ACT_FWD: begin
        if ($signed(it.tgt) <= 0) begin
          goal_pos = POS_MAX;
          sw_mark_ok[1] = 1'b0;
        end else begin
          goal_pos = count_pos + it.tgt;
        end
        start_motion();
      end
      ACT_REV: begin
        if ($signed(it.tgt) > 0) begin
          goal_pos = count_pos - it.tgt;
          start_motion();
        end else begin
          ok = 1'b0;
        end
      end
      ACT_GOTO: begin
        if (sw_mark_ok[0] && drive_mode <= RUN_CODE_REV) begin
          goal_pos = it.tgt + sw_mark[0];
          start_motion();
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
    r.motor_fwd = (drive_mode == RUN_CODE_FWD);
    r.motor_rev = (drive_mode == RUN_CODE_REV);
    r.run_state = drive_mode;
    r.position = sw_mark_ok[0] ? count_pos - sw_mark[0] : count_pos;
    r.limit_a_hit = (sw_state[0] == SW_HIGH);
    r.limit_b_hit = (sw_state[1] == SW_HIGH);
    r.limit_a_pos = sw_mark_ok[0] ? sw_mark[0] : '0;
    r.limit_b_pos = sw_mark_ok[1] ? sw_mark[1] : '0;
    r.home_set = sw_mark_ok[0];
    r.accepted = ok;
    r.settled = calm;
    return r;
  endfunction

  function automatic item_t mk(logic [3:0] a, logic [31:0] t, logic [31:0] h,
                               logic [31:0] f, logic p);
    item_t it;
    it.act = a;
    it.tgt = t;
    it.home = h;
    it.far = f;
    it.pin = p;
    return it;
  endfunction

  // mostly short moves so that position stops are reached, now and then any value
  function automatic logic [31:0] pick_steps();
    if ($urandom_range(99) < 75) return $urandom_range(34) - 4;
    return $urandom();
  endfunction

  task automatic push_random(int n);
    int    r;
    item_t it;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      it = mk(ACT_TICK, $urandom(), $urandom(), $urandom(), 1'($urandom_range(1)));
      if (r < 38) begin
        it.act = ACT_TICK;
      end else if (r < 70) begin
        it.act = ACT_ENC;
      end else if (r < 78) begin
        it.act = $urandom_range(1) ? ACT_LIM_B : ACT_LIM_A;
      end else if (r < 94) begin
        case ($urandom_range(3))
          0: it.act = ACT_HOME;
          1: it.act = ACT_FWD;
          2: it.act = ACT_REV;
          default: it.act = ACT_GOTO;
        endcase
        it.tgt = pick_steps();
      end else if (r < 97) begin
        it.act = ACT_INIT;
      end else begin
        it.act = 4'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      end
      pending_items.push_back(it);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_DEB_A:   regs.deb_a = val;
      CFG_DEB_B:   regs.deb_b = val;
      CFG_ENC_TMO: regs.enc_tmo = val;
      CFG_ENABLE:  regs.enable = val[2:0];
      CFG_INVERT:  regs.invert = val[1:0];
      default:     regs.margin = val[15:0];
    endcase
  endtask

  task automatic setup_registers(logic [31:0] deb_a, logic [31:0] deb_b,
                                 logic [31:0] tmo, logic [31:0] en,
                                 logic [31:0] inv, logic [31:0] margin);
    write_reg(CFG_DEB_A, deb_a);
    write_reg(CFG_DEB_B, deb_b);
    write_reg(CFG_ENC_TMO, tmo);
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_INVERT, inv);
    write_reg(CFG_MARGIN, margin);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every transaction is sent and answered, then let the pipeline drain
  task automatic settle();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // input driver: presents queued transactions, holds them until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_results.push_back(positioner_step(cur_item));
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cur_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          action_i <= cur_item.act;
          target_i <= cur_item.tgt;
          home_pos_i <= cur_item.home;
          far_pos_i <= cur_item.far;
          pin_level_i <= cur_item.pin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.motor_fwd = motor_fwd_o;
        got.motor_rev = motor_rev_o;
        got.run_state = run_state_o;
        got.position = position_o;
        got.limit_a_hit = limit_a_hit_o;
        got.limit_b_hit = limit_b_hit_o;
        got.limit_a_pos = limit_a_pos_o;
        got.limit_b_pos = limit_b_pos_o;
        got.home_set = home_set_o;
        got.accepted = accepted_o;
        got.settled = settled_o;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual %p",
                   $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("motor_fwd", want.motor_fwd, got.motor_fwd);
          check_field("motor_rev", want.motor_rev, got.motor_rev);
          check_field("run_state", want.run_state, got.run_state);
          check_field("position", want.position, got.position);
          check_field("limit_a_hit", want.limit_a_hit, got.limit_a_hit);
          check_field("limit_b_hit", want.limit_b_hit, got.limit_b_hit);
          check_field("limit_a_pos", want.limit_a_pos, got.limit_a_pos);
          check_field("limit_b_pos", want.limit_b_pos, got.limit_b_pos);
          check_field("home_set", want.home_set, got.home_set);
          check_field("accepted", want.accepted, got.accepted);
          check_field("settled", want.settled, got.settled);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // count cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // reset, directed sequence, then random phases under changing registers
  initial begin
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_gap_pct = 16;
    recv_gap_pct = 65;
    setup_registers(32'd1, 32'd0, 32'd2, 32'd7, 32'd0, 32'd3);

    // before init: tick, ignored edge and switch change, refused commands
    pending_items.push_back(mk(ACT_TICK, 0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_ENC, 0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_LIM_A, 0, 0, 0, 1'b1));
    pending_items.push_back(mk(ACT_GOTO, 32'd5, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_REV, 32'd0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_REV, POS_MIN, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_UNUSED_LO, POS_MAX, POS_MIN, POS_MAX, 1'b1));
    pending_items.push_back(mk(ACT_UNUSED_HI, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1));
    // init with a known home, go-to accepted from idle, repeated init ignored
    pending_items.push_back(mk(ACT_INIT, 32'd10, -32'sd20, POS_MAX, 1'b0));
    pending_items.push_back(mk(ACT_GOTO, POS_MIN, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_INIT, 32'd1, 32'd1, 32'd1, 1'b1));
    // short forward move, stop margin ends it early
    pending_items.push_back(mk(ACT_FWD, 32'd4, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_ENC, 0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_TICK, 0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_GOTO, POS_MAX, 0, 0, 1'b0));
    // run to the far limit, switch b debounces and stops the motor
    pending_items.push_back(mk(ACT_FWD, CNT_MAX, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_ENC, 0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_LIM_B, 0, 0, 0, 1'b1));
    pending_items.push_back(mk(ACT_TICK, 0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_LIM_B, 0, 0, 0, 1'b0));
    // long reverse with no encoder edges runs into the timeout
    pending_items.push_back(mk(ACT_REV, POS_MAX, 0, 0, 1'b0));
    repeat (3) pending_items.push_back(mk(ACT_TICK, 0, 0, 0, 1'b0));
    // find home, switch a debounces and latches
    pending_items.push_back(mk(ACT_HOME, 0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_LIM_A, 0, 0, 0, 1'b1));
    repeat (2) pending_items.push_back(mk(ACT_TICK, 0, 0, 0, 1'b0));
    pending_items.push_back(mk(ACT_GOTO, POS_MIN, 0, 0, 1'b0));
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_gap_pct = 16;
        recv_gap_pct = 65;
      end else if (phase < 4) begin
        send_gap_pct = 65;
        recv_gap_pct = 16;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      case (phase)
        0: setup_registers(32'd0, 32'd3, 32'd5, 32'd7, 32'd0, 32'd0);
        1: setup_registers(CNT_MAX, CNT_MAX, CNT_MAX, 32'd3, 32'd3, 32'd65535);
        2: setup_registers(32'd2, 32'd1, 32'd0, 32'd7, 32'd1, 32'd2);
        3: setup_registers($urandom_range(4), $urandom_range(4), $urandom_range(8),
                           32'd0, 32'd2, 32'd1);
        4: setup_registers($urandom_range(4), $urandom_range(4), $urandom_range(12, 2),
                           $urandom_range(7), $urandom_range(3), $urandom_range(5));
        default: setup_registers($urandom_range(4), $urandom_range(4),
                                 $urandom_range(15, 3), 32'd7, 32'd0, $urandom_range(8));
      endcase
      push_random(CHUNK_ITEMS);
      settle();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mpl_pkg.sv
hw/rtl/mpl_sw_debounce.sv
hw/rtl/mpl_core.sv
hw/rtl/motor_positioner_with_limits.sv
hw/rtl/mpl_checker.sv
dv/motor_positioner_with_limits_tb.sv
